FILE: hdl/per_id_message_rate_limiter_defines.svh
// assertion macros for the per-id message rate limiter
// used by the top level; needs i_clk and i_rst_n in the including scope
`ifndef PER_ID_MESSAGE_RATE_LIMITER_DEFINES_SVH
`define PER_ID_MESSAGE_RATE_LIMITER_DEFINES_SVH

// consequent checked in the same cycle
`define PMRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmrl assertion failed");

// consequent checked in the cycle after the antecedent
`define PMRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmrl assertion failed");

`endif

FILE: hdl/pmrl_pkg.sv
// shared types, constants and index helpers for the message rate limiter
// no dependencies
`timescale 1ns / 1ps

package pmrl_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = IDX_W;

    localparam int ID_W       = 16;
    localparam int SRC_W      = 8;
    localparam int TIME_W     = 48;
    localparam int IVL_W      = 16;
    localparam int WIN_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(RING_DEPTH - 1);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);
    localparam logic [SRC_W-1:0] SOURCE_RESET = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = CFG_IDX_W'(1);

    // command codes
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_PUSH  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [ID_W-1:0]   id;
        logic [SRC_W-1:0]  src;
        logic [TIME_W-1:0] stamp;
    } t_ring_wr;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [SRC_W-1:0]  src;
        logic [TIME_W-1:0] stamp;
    } t_ring_rd;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

endpackage

FILE: hdl/pmrl_ring.sv
// message ring storage: one write port, one registered read port
// per-slot valid bits cleared by reset; depends on pmrl_pkg
`timescale 1ns / 1ps

module pmrl_ring (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pmrl_pkg::t_ring_wr             i_wr,
    input  logic [pmrl_pkg::IDX_W-1:0]     i_rd_addr,
    output pmrl_pkg::t_ring_rd             o_rd
);
    import pmrl_pkg::*;

    localparam int ENTRY_W = ID_W + SRC_W + TIME_W;

    logic [ENTRY_W-1:0]    r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [ENTRY_W-1:0]    r_rd_data;
    logic                  r_rd_valid;

    // payload array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.id, i_wr.src, i_wr.stamp};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.id    = r_rd_data[ENTRY_W-1 -: ID_W];
    assign o_rd.src   = r_rd_data[TIME_W +: SRC_W];
    assign o_rd.stamp = r_rd_data[TIME_W-1:0];

endmodule

FILE: hdl/per_id_message_rate_limiter.sv
// sequence: a push, or a check with interval 0, goes straight to the finish step;
// other checks walk k entries (1 to RING_DEPTH-1), newest first, before finishing
// one item at a time: the next is taken once the result is in the output register;
// the ring walk reads one slot per cycle through one memory read port
// reset (synchronous, active low): ring empty, write index 0, window 1000, source 0
`timescale 1ns / 1ps

`include "per_id_message_rate_limiter_defines.svh"

// top level: sequencer walking the ring with one shared age subtract/compare unit
// depends on pmrl_pkg, pmrl_ring and per_id_message_rate_limiter_defines.svh
module per_id_message_rate_limiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [pmrl_pkg::ID_W-1:0]           i_msg_id,
    input  logic [pmrl_pkg::SRC_W-1:0]          i_source,
    input  logic [pmrl_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [pmrl_pkg::IVL_W-1:0]          i_interval_ms,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_limited,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pmrl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pmrl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pmrl_pkg::*;

    // sequencer state
    t_state             r_state;
    t_state             n_state;

    // ring position: write pointer, walk pointer and remaining walk steps
    logic [IDX_W-1:0]   r_wr_idx;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [CNT_W-1:0]   r_left;
    logic [CNT_W-1:0]   n_left;

    // captured check beat
    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_now;
    logic [IVL_W-1:0]   r_interval;

    // configuration
    logic [WIN_W-1:0]   r_window;
    logic [SRC_W-1:0]   r_source;

    // pending answer and output register
    logic               r_res;
    logic               n_res;
    logic               r_out_valid;
    logic               r_limited;
    logic               out_load;

    // handshakes
    logic               in_fire;
    logic               cfg_fire;

    // ring port
    t_ring_wr           ring_wr;
    t_ring_rd           ring_rd;
    logic [IDX_W-1:0]   rd_addr;

    // shared age unit
    logic [TIME_W:0]    age;
    logic               age_neg;
    logic               ge_window;
    logic               lt_interval;
    logic               end_clear;
    logic               hit;
    logic               last_step;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    pmrl_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ring_wr),
        .i_rd_addr (rd_addr),
        .o_rd      (ring_rd)
    );

    // age of the slot whose data is on the read port; a future stamp gives a
    // negative age, which is inside both windows
    assign age     = {1'b0, r_now} - {1'b0, ring_rd.stamp};
    assign age_neg = age[TIME_W];

    assign ge_window   = !age_neg &&
                         ((age[TIME_W-1:WIN_W] != '0) || (age[WIN_W-1:0] >= r_window));
    assign lt_interval = age_neg ||
                         ((age[TIME_W-1:IVL_W] == '0) && (age[IVL_W-1:0] < r_interval));

    // empty slot, id zero or an entry at or past the window ends the walk clear
    assign end_clear = !ring_rd.valid || (ring_rd.id == '0) || ge_window;
    assign hit       = (ring_rd.id == r_id) && (ring_rd.src == r_source) && lt_interval;
    assign last_step = (r_left == CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_command == CMD_PUSH || i_interval_ms == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (end_clear || hit || last_step) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        n_idx         = r_idx;
        n_left        = r_left;
        n_res         = r_res;
        rd_addr       = r_idx;
        out_load      = 1'b0;
        ring_wr.en    = 1'b0;
        ring_wr.addr  = r_wr_idx;
        ring_wr.id    = i_msg_id;
        ring_wr.src   = i_source;
        ring_wr.stamp = i_now_ms;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // newest slot sits just behind the write pointer
                    n_idx      = prev_idx(r_wr_idx);
                    n_left     = CNT_W'(RING_DEPTH - 1);
                    n_res      = 1'b0;
                    ring_wr.en = (i_command == CMD_PUSH);
                end
            end
            S_START: begin
                rd_addr = r_idx;
            end
            S_WALK: begin
                // evaluate current slot, fetch the one before it
                rd_addr = prev_idx(r_idx);
                n_idx   = prev_idx(r_idx);
                n_left  = r_left - CNT_W'(1);
                n_res   = hit && !end_clear;
            end
            S_FIN: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
            r_window    <= WINDOW_RESET;
            r_source    <= SOURCE_RESET;
        end else begin
            r_state <= n_state;
            if (ring_wr.en) begin
                r_wr_idx <= next_idx(r_wr_idx);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                    CFG_SOURCE: r_source <= i_cfg_data[SRC_W-1:0];
                    default: begin
                        // unknown index, write dropped
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_res  <= n_res;
        if (in_fire) begin
            r_id       <= i_msg_id;
            r_now      <= i_now_ms;
            r_interval <= i_interval_ms;
        end
        if (out_load) begin
            r_limited <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_limited   = r_limited;

    // a walk never runs with no steps left
    `PMRL_ASSERT_NOW(a_walk_left, r_state == S_WALK, r_left != '0)
    // write pointer stays inside the ring
    `PMRL_ASSERT_NOW(a_wr_idx_range, 1'b1, r_wr_idx <= LAST_IDX)
    // a push advances the write pointer by one slot
    `PMRL_ASSERT_NEXT(a_push_adv, ring_wr.en, r_wr_idx == next_idx($past(r_wr_idx)))
    // results appear only out of the finish step
    `PMRL_ASSERT_NEXT(a_out_src, !r_out_valid && r_state != S_FIN, !r_out_valid)

endmodule

FILE: bench/per_id_message_rate_limiter_test.sv
// self-checking bench for the per-id message rate limiter: a directed table, then random phases
// that each use their own window and source, most with idle bursts on item and result channels
// depends on pmrl_pkg and per_id_message_rate_limiter
`timescale 1ns / 1ps

module per_id_message_rate_limiter_test;
    import pmrl_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          PHASES          = 8;
    localparam int          BEATS_PER_PHASE = 125;
    localparam int          PLAN_ROWS       = 19;

    localparam logic [WIN_W-1:0]  WINDOW_AT_RESET = 16'd1000;
    localparam logic [TIME_W-1:0] MAX_MS          = '1;
    // register indexes from here up hit no register
    localparam int unsigned       FIRST_SPARE_REG = 2;

    // one message beat on the item channel
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [SRC_W-1:0]  src;
        logic [TIME_W-1:0] now;
        logic [IVL_W-1:0]  ivl;
    } t_msg_beat;

    // directed row: a beat, plus an answer typed in when it is obvious
    typedef struct packed {
        t_msg_beat beat;
        logic      typed;
        logic      want;
    } t_plan_row;

    // dut ports, inputs all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic                  i_command     = CMD_CHECK;
    logic [ID_W-1:0]       i_msg_id      = '0;
    logic [SRC_W-1:0]      i_source      = '0;
    logic [TIME_W-1:0]     i_now_ms      = '0;
    logic [IVL_W-1:0]      i_interval_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic                  o_limited;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    per_id_message_rate_limiter DUT (.*);

    // shadow of the message ring and the two registers
    logic [ID_W-1:0]   ring_id    [RING_DEPTH];
    logic [SRC_W-1:0]  ring_src   [RING_DEPTH];
    logic [TIME_W-1:0] ring_stamp [RING_DEPTH];
    logic              ring_vld   [RING_DEPTH];
    int unsigned       wr_ptr;
    logic [WIN_W-1:0]  win_ms;
    logic [SRC_W-1:0]  lim_src;

    // limited answers still owed by the block, oldest first
    bit                limited_due [$];
    int unsigned       fail_count  = 0;
    int unsigned       cycle_count = 0;
    bit                idle_on     = 1'b1;
    // running time base for random traffic
    logic [TIME_W-1:0] msg_clock;

    // directed stimulus on reset config (window 1000, source 0)
    t_plan_row plan [PLAN_ROWS] = '{
        // empty ring after reset answers not limited
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd100,  16'd50},    1'b1, 1'b0},
        '{'{CMD_PUSH,  16'd5,     8'd0,   48'd100,  16'd0},     1'b1, 1'b0},
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd120,  16'd50},    1'b0, 1'b0},
        // interval zero never limits
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd120,  16'd0},     1'b1, 1'b0},
        // age equal to the interval is not limited
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd150,  16'd50},    1'b0, 1'b0},
        // age equal to the window ends the walk, one less still counts
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd1100, 16'hFFFF},  1'b0, 1'b0},
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd1099, 16'hFFFF},  1'b0, 1'b0},
        // an id zero entry stops the walk
        '{'{CMD_PUSH,  16'd0,     8'd0,   48'd200,  16'd0},     1'b1, 1'b0},
        '{'{CMD_CHECK, 16'd5,     8'd0,   48'd201,  16'd1000},  1'b0, 1'b0},
        // all-ones push, interval field ignored on push
        '{'{CMD_PUSH,  16'hFFFF,  8'hFF,  MAX_MS,   16'hFFFF},  1'b1, 1'b0},
        // stamps in the future, wrong source
        '{'{CMD_CHECK, 16'hFFFF,  8'd0,   48'd0,    16'hFFFF},  1'b0, 1'b0},
        '{'{CMD_PUSH,  16'd7,     8'd0,   48'd5000, 16'd0},     1'b1, 1'b0},
        // future stamp counts as inside, check source is ignored
        '{'{CMD_CHECK, 16'd7,     8'hFF,  48'd4990, 16'd1},     1'b0, 1'b0},
        '{'{CMD_PUSH,  16'hFFFF,  8'd0,   MAX_MS,   16'd0},     1'b1, 1'b0},
        '{'{CMD_CHECK, 16'hFFFF,  8'd0,   MAX_MS,   16'hFFFF},  1'b0, 1'b0},
        '{'{CMD_CHECK, 16'hFFFF,  8'd0,   MAX_MS,   16'd1},     1'b0, 1'b0},
        '{'{CMD_CHECK, 16'd0,     8'd0,   MAX_MS,   16'd1},     1'b0, 1'b0},
        '{'{CMD_CHECK, 16'h8000,  8'h80,  48'h8000_0000_0000, 16'h8000}, 1'b0, 1'b0},
        '{'{CMD_CHECK, 16'hAAAA,  8'h55,  48'h5555_AAAA_5555, 16'h5555}, 1'b0, 1'b0}
    };

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // hard stop if the block hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** per_id_message_rate_limiter: FAILED **");
        $finish;
    end

    // applies one beat to the shadow ring and returns the limited answer
    function automatic bit rate_predict(input t_msg_beat b);
        int unsigned slot;
        longint      age;
        if (b.cmd == CMD_PUSH) begin
            ring_id[wr_ptr]    = b.id;
            ring_src[wr_ptr]   = b.src;
            ring_stamp[wr_ptr] = b.now;
            ring_vld[wr_ptr]   = 1'b1;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            return 1'b0;
        end
        if (b.ivl == '0)
            return 1'b0;
        slot = (wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
        // newest first, the slot about to be overwritten is never looked at
        for (int n = 0; n < RING_DEPTH - 1; n++) begin
            if (!ring_vld[slot] || ring_id[slot] == '0)
                return 1'b0;
            // signed age, a future stamp gives a negative one
            age = longint'({16'd0, b.now}) - longint'({16'd0, ring_stamp[slot]});
            if (age >= longint'(win_ms))
                return 1'b0;
            if (ring_id[slot] == b.id && ring_src[slot] == lim_src && age < longint'(b.ivl))
                return 1'b1;
            slot = (slot + RING_DEPTH - 1) % RING_DEPTH;
        end
        return 1'b0;
    endfunction

    // random beat: small id pool and a slowly moving clock so that hits happen
    function automatic t_msg_beat next_random_beat();
        t_msg_beat   b;
        int unsigned pick;
        int unsigned span;
        span  = (win_ms < 16) ? 16 : win_ms;
        b.cmd = $urandom_range(0, 1) ? CMD_PUSH : CMD_CHECK;
        pick  = $urandom_range(0, 99);
        if (pick < 80)
            b.id = ID_W'($urandom_range(1, 4));
        else if (pick < 88)
            b.id = '0;
        else
            b.id = ID_W'($urandom);
        b.src = ($urandom_range(0, 3) != 0) ? lim_src : SRC_W'($urandom);
        msg_clock = msg_clock + TIME_W'($urandom_range(0, span / 3));
        pick = $urandom_range(0, 99);
        if (pick < 80)
            b.now = msg_clock;
        else if (pick < 92)
            b.now = msg_clock - TIME_W'($urandom_range(0, span));
        else if (pick < 96)
            b.now = msg_clock + TIME_W'($urandom_range(0, span));
        else
            b.now = TIME_W'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 10)
            b.ivl = '0;
        else if (pick < 20)
            b.ivl = IVL_W'($urandom);
        else if (pick < 25)
            b.ivl = '1;
        else
            b.ivl = IVL_W'($urandom_range(1, span));
        return b;
    endfunction

    // drive one beat until accepted, then record what should come back
    task automatic send_beat(input t_msg_beat b, input bit typed, input bit want);
        bit pred;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= b.cmd;
        i_msg_id      <= b.id;
        i_source      <= b.src;
        i_now_ms      <= b.now;
        i_interval_ms <= b.ivl;
        do @(posedge i_clk); while (!o_in_ready);
        pred = rate_predict(b);
        limited_due.push_back(typed ? want : pred);
    endtask

    // stop sending and wait for every owed answer
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (limited_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WINDOW)
            win_ms = data;
        else if (idx == CFG_SOURCE)
            lim_src = data[SRC_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stalls, every beat checked against the oldest answer owed
    initial begin : result_side
        int unsigned stall_left;
        bit          want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (limited_due.size() == 0) begin
                    $display("%0t: result beat with none owed, expected nothing actual %0b",
                             $time, o_limited);
                    fail_count++;
                end else begin
                    want = limited_due.pop_front();
                    if (o_limited !== want) begin
                        $display("%0t: limited mismatch, expected %0b actual %0b",
                                 $time, want, o_limited);
                        fail_count++;
                    end
                end
            end
            // a stall still running when idling is switched off ends at once
            if (idle_on && stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = 0;
            end
        end
    end

    initial begin : stimulus
        t_msg_beat        b;
        logic [WIN_W-1:0] w;
        logic [SRC_W-1:0] s;

        // shadow state matches the block after reset
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_id[k]    = '0;
            ring_src[k]   = '0;
            ring_stamp[k] = '0;
            ring_vld[k]   = 1'b0;
        end
        wr_ptr  = 0;
        win_ms  = WINDOW_AT_RESET;
        lim_src = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table on the reset configuration
        for (int r = 0; r < PLAN_ROWS; r++)
            send_beat(plan[r].beat, plan[r].typed, plan[r].want);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // one quiet phase in the middle, and the last one quiet too
            idle_on = (p != 4) && (p != PHASES - 1);
            case (p)
                0: begin
                    w = '0;
                    s = '0;
                end
                1: begin
                    w = '1;
                    s = '1;
                end
                2: begin
                    w = 16'd1;
                    s = SRC_W'($urandom);
                end
                default: begin
                    w = WIN_W'($urandom_range(2, 3000));
                    s = ($urandom_range(0, 2) == 0) ? '0 : SRC_W'($urandom);
                end
            endcase
            // upper data bits of the source write must be dropped
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_SOURCE, {8'($urandom), s});
                write_reg(CFG_WINDOW, w);
            end else begin
                write_reg(CFG_WINDOW, w);
                write_reg(CFG_SOURCE, {8'($urandom), s});
            end
            // write to an index with no register behind it
            write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, 255)), CFG_DATA_W'($urandom));

            msg_clock = (p == 1) ? MAX_MS - TIME_W'($urandom_range(0, 200000))
                                 : TIME_W'({$urandom, $urandom});
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 59) == 0)
                    drain();
                b = next_random_beat();
                send_beat(b, 1'b0, 1'b0);
            end
            drain();
        end

        // let a stray late beat show up before the verdict
        repeat (RING_DEPTH + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("** per_id_message_rate_limiter: PASSED **");
        else
            $display("** per_id_message_rate_limiter: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/pmrl_pkg.sv
hdl/pmrl_ring.sv
hdl/per_id_message_rate_limiter.sv
bench/per_id_message_rate_limiter_test.sv
